// ===== hdl/lzes_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lzes_pkg
// Shared types and constants of the Lorenz Euler step unit.
// ----------------------------------------------------------------------------
package lzes_pkg;

  localparam int unsigned CoordW    = 32;  // Q8.24 coordinate
  localparam int unsigned CoefW     = 32;  // Q8.24 coefficient
  localparam int unsigned DtW       = 25;  // unsigned Q1.24 time step
  localparam int unsigned FracW     = 24;  // fraction bits
  localparam int unsigned DiffW     = 33;  // Q9.24 difference
  localparam int unsigned TermW     = 41;  // reduced product
  localparam int unsigned DerivW    = 42;  // derivative
  localparam int unsigned HiW       = DerivW - FracW;       // 18
  localparam int unsigned PartHiW   = DtW + 1 + HiW;        // 44
  localparam int unsigned PartLoW   = DtW;                  // 25
  localparam int unsigned StepW     = PartHiW + 1;          // 45
  localparam int unsigned SumW      = StepW + 1;            // 46
  localparam int unsigned NumStages = 6;
  localparam int unsigned FrontStages = 3;
  localparam int unsigned CfgIdxW   = 4;
  localparam int unsigned CfgDataW  = 32;

  localparam logic signed [CoefW-1:0] SigmaRst = 32'sd167772160;
  localparam logic signed [CoefW-1:0] RhoRst   = 32'sd469762048;
  localparam logic signed [CoefW-1:0] BetaRst  = 32'sd44739243;
  localparam logic        [DtW-1:0]   DtRst    = 25'd16777;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSigma    = 4'd0,
    CfgRho      = 4'd1,
    CfgBeta     = 4'd2,
    CfgTimeStep = 4'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [CoefW-1:0] sigma;
    logic signed [CoefW-1:0] rho;
    logic signed [CoefW-1:0] beta;
    logic        [DtW-1:0]   time_step;
  } cfg_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } point_t;

  typedef struct packed {
    logic signed [DerivW-1:0] dx;
    logic signed [DerivW-1:0] dy;
    logic signed [DerivW-1:0] dz;
  } deriv_t;

endpackage
`default_nettype wire

// ===== hdl/lorenz_euler_step_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lorenz_euler_step_unit
// One explicit Euler step of the Lorenz system on signed Q8.24 points.
// ----------------------------------------------------------------------------
// Each input word (cur_x, cur_y, cur_z) leaves as one result word
// (next_x, next_y, next_z, saturated), and while the output is not stalled a
// new point can be accepted in every cycle, so the sustained rate is one point
// per clock. The six register stages are: differences y-x and rho-z; two
// 32x33 and two 32x32 products reduced by floor to Q.24; derivative sums; the
// dt multiply split into a high and a fraction part; the step sum; the final add
// with saturation into the output register. Each stage holds its word while
// the one after it is full and stalled, so a waiting result does not stop
// words already in flight from moving up. Sigma, rho, beta and time_step
// reset to 10, 28, about 8/3 and about 0.001; write them only while no word
// is in flight. Writes to an unknown register index are dropped.
module lorenz_euler_step_unit (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic signed [lzes_pkg::CoordW-1:0]    cur_x_i,
  input  wire logic signed [lzes_pkg::CoordW-1:0]    cur_y_i,
  input  wire logic signed [lzes_pkg::CoordW-1:0]    cur_z_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic signed [lzes_pkg::CoordW-1:0]         next_x_o,
  output logic signed [lzes_pkg::CoordW-1:0]         next_y_o,
  output logic signed [lzes_pkg::CoordW-1:0]         next_z_o,
  output logic                                       saturated_o,
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [lzes_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  wire logic [lzes_pkg::CfgDataW-1:0]         cfg_data_i
);

  localparam int unsigned NS = lzes_pkg::NumStages;
  localparam int unsigned NF = lzes_pkg::FrontStages;

  lzes_pkg::cfg_t   cfg;
  lzes_pkg::point_t pt_in, pt_mid, pt_out;
  lzes_pkg::deriv_t der_mid;

  // per-stage handshake: a stage takes a word when it is empty or its own
  // word moves on in the same cycle
  logic [NS-1:0] v_q, v_d;
  logic [NS:0]   rdy;
  logic [NS-1:0] vin;
  logic [NS-1:0] en;

  assign rdy[NS] = out_ready_i;
  assign vin     = {v_q[NS-2:0], in_valid_i};

  for (genvar k = 0; k < NS; k++) begin : g_ctl
    assign rdy[k] = !v_q[k] || rdy[k+1];
    assign en[k]  = vin[k] && rdy[k];
    assign v_d[k] = rdy[k] ? vin[k] : v_q[k];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  // config port never stalls
  assign cfg_ready_o = 1'b1;

  lzes_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign pt_in.x = cur_x_i;
  assign pt_in.y = cur_y_i;
  assign pt_in.z = cur_z_i;

  lzes_deriv u_deriv (
    .clk_i (clk_i),
    .en_i  (en[NF-1:0]),
    .cfg_i (cfg),
    .pt_i  (pt_in),
    .pt_o  (pt_mid),
    .der_o (der_mid)
  );

  lzes_integrate u_integrate (
    .clk_i (clk_i),
    .en_i  (en[NS-1:NF]),
    .dt_i  (cfg.time_step),
    .pt_i  (pt_mid),
    .der_i (der_mid),
    .pt_o  (pt_out),
    .sat_o (saturated_o)
  );

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NS-1];
  assign next_x_o    = pt_out.x;
  assign next_y_o    = pt_out.y;
  assign next_z_o    = pt_out.z;

`ifndef SYNTHESIS
  // an accepted word lands in the first stage
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v_q[0])
    else $error("accepted word missing from first stage");

  // a full pipe with a stalled output takes nothing
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&v_q) && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while pipe full and stalled");

  // a result only appears from the stage before it
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(v_q[NS-2]))
    else $error("result appeared without a source word");

  // the flag implies a coordinate at a Q8.24 limit
  a_sat_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |->
      ((next_x_o == 32'sh7fffffff) || (next_x_o == 32'sh80000000) ||
       (next_y_o == 32'sh7fffffff) || (next_y_o == 32'sh80000000) ||
       (next_z_o == 32'sh7fffffff) || (next_z_o == 32'sh80000000)))
    else $error("saturation flag without clipped coordinate");
`endif

endmodule
`default_nettype wire

// ===== hdl/lzes_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lzes_cfg_regs
// Coefficient and time step registers, written through the config port.
// ----------------------------------------------------------------------------
module lzes_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic [lzes_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [lzes_pkg::CfgDataW-1:0] cfg_data_i,
  output lzes_pkg::cfg_t                     cfg_o
);

  lzes_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        lzes_pkg::CfgSigma:    cfg_d.sigma     = cfg_data_i;
        lzes_pkg::CfgRho:      cfg_d.rho       = cfg_data_i;
        lzes_pkg::CfgBeta:     cfg_d.beta      = cfg_data_i;
        lzes_pkg::CfgTimeStep: cfg_d.time_step = cfg_data_i[lzes_pkg::DtW-1:0];
        default:               cfg_d           = cfg_q;  // drop unknown index
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sigma     <= lzes_pkg::SigmaRst;
      cfg_q.rho       <= lzes_pkg::RhoRst;
      cfg_q.beta      <= lzes_pkg::BetaRst;
      cfg_q.time_step <= lzes_pkg::DtRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ===== hdl/lzes_deriv.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lzes_deriv
// Stages 1 to 3: differences, four wide products, derivative sums.
// ----------------------------------------------------------------------------
module lzes_deriv (
  input  wire logic                                clk_i,
  input  wire logic [lzes_pkg::FrontStages-1:0]    en_i,
  input  wire lzes_pkg::cfg_t                      cfg_i,
  input  wire lzes_pkg::point_t                    pt_i,
  output lzes_pkg::point_t                         pt_o,
  output lzes_pkg::deriv_t                         der_o
);

  localparam int unsigned DW = lzes_pkg::DiffW;
  localparam int unsigned TW = lzes_pkg::TermW;
  localparam int unsigned RW = lzes_pkg::DerivW;
  localparam int unsigned FW = lzes_pkg::FracW;
  localparam int unsigned CoefPad = lzes_pkg::CoefW;

  // stage 1: differences
  lzes_pkg::point_t        pt1_q;
  logic signed [DW-1:0]    dyx_q, drz_q;
  // stage 2: reduced products
  lzes_pkg::point_t        pt2_q;
  logic signed [TW-1:0]    t_sig_q, t_xr_q, t_xy_q, t_bz_q;
  // stage 3: derivatives
  lzes_pkg::point_t        pt3_q;
  lzes_pkg::deriv_t        der_q;

  logic signed [DW-1:0]    dyx_d, drz_d;
  logic signed [DW+CoefPad-1:0] p_sig, p_xr;
  logic signed [2*lzes_pkg::CoordW-1:0] p_xy, p_bz;
  lzes_pkg::deriv_t        der_d;

  always_comb begin
    dyx_d = $signed({pt_i.y[lzes_pkg::CoordW-1], pt_i.y})
          - $signed({pt_i.x[lzes_pkg::CoordW-1], pt_i.x});
    drz_d = $signed({cfg_i.rho[lzes_pkg::CoefW-1], cfg_i.rho})
          - $signed({pt_i.z[lzes_pkg::CoordW-1], pt_i.z});
  end

  // exact products, floor by dropping the fraction bits
  always_comb begin
    p_sig = cfg_i.sigma * dyx_q;
    p_xr  = pt1_q.x * drz_q;
    p_xy  = pt1_q.x * pt1_q.y;
    p_bz  = cfg_i.beta * pt1_q.z;
  end

  always_comb begin
    der_d.dx = RW'(t_sig_q);
    der_d.dy = RW'(t_xr_q) - RW'(pt2_q.y);
    der_d.dz = RW'(t_xy_q) - RW'(t_bz_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pt1_q <= pt_i;
      dyx_q <= dyx_d;
      drz_q <= drz_d;
    end
    if (en_i[1]) begin
      pt2_q   <= pt1_q;
      t_sig_q <= p_sig[DW+CoefPad-1:FW];
      t_xr_q  <= p_xr[DW+CoefPad-1:FW];
      t_xy_q  <= TW'($signed(p_xy[2*lzes_pkg::CoordW-1:FW]));
      t_bz_q  <= TW'($signed(p_bz[2*lzes_pkg::CoordW-1:FW]));
    end
    if (en_i[2]) begin
      pt3_q <= pt2_q;
      der_q <= der_d;
    end
  end

  assign pt_o  = pt3_q;
  assign der_o = der_q;

endmodule
`default_nettype wire

// ===== hdl/lzes_integrate.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lzes_integrate
// Stages 4 to 6: split dt multiply, step sum, coordinate add and saturate.
// ----------------------------------------------------------------------------
module lzes_integrate (
  input  wire logic                                           clk_i,
  input  wire logic [lzes_pkg::NumStages-lzes_pkg::FrontStages-1:0] en_i,
  input  wire logic [lzes_pkg::DtW-1:0]                       dt_i,
  input  wire lzes_pkg::point_t                               pt_i,
  input  wire lzes_pkg::deriv_t                               der_i,
  output lzes_pkg::point_t                                    pt_o,
  output logic                                                sat_o
);

  localparam int unsigned HW  = lzes_pkg::PartHiW;
  localparam int unsigned LW  = lzes_pkg::PartLoW;
  localparam int unsigned SW  = lzes_pkg::StepW;
  localparam int unsigned UW  = lzes_pkg::SumW;
  localparam int unsigned FW  = lzes_pkg::FracW;
  localparam int unsigned CW  = lzes_pkg::CoordW;
  localparam int unsigned DtW = lzes_pkg::DtW;

  lzes_pkg::point_t        pt4_q, pt5_q, out_q;
  logic signed [HW-1:0]    hi_q [3];
  logic        [LW-1:0]    lo_q [3];
  logic signed [SW-1:0]    step_q [3];
  logic                    sat_q;

  logic signed [HW-1:0]    hi_d [3];
  logic        [LW-1:0]    lo_d [3];
  logic signed [SW-1:0]    step_d [3];
  logic signed [CW-1:0]    crd5 [3];
  logic signed [CW-1:0]    res_d [3];
  logic        [2:0]       clip;
  logic signed [lzes_pkg::DerivW-1:0] der [3];
  logic        [DtW+FW-1:0] lo_prod [3];
  logic signed [UW-1:0]    sum [3];

  assign der[0]  = der_i.dx;
  assign der[1]  = der_i.dy;
  assign der[2]  = der_i.dz;
  assign crd5[0] = pt5_q.x;
  assign crd5[1] = pt5_q.y;
  assign crd5[2] = pt5_q.z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // dt * floor(d / 2^24) plus floor(dt * frac(d) / 2^24)
      hi_d[i]    = $signed({1'b0, dt_i}) * $signed(der[i][lzes_pkg::DerivW-1:FW]);
      lo_prod[i] = dt_i * der[i][FW-1:0];
      lo_d[i]    = lo_prod[i][DtW+FW-1:FW];
      step_d[i]  = SW'(hi_q[i]) + $signed({{(SW-LW){1'b0}}, lo_q[i]});
      sum[i]     = UW'(crd5[i]) + UW'(step_q[i]);
      clip[i]    = (sum[i][UW-1:CW-1] != '0) && (sum[i][UW-1:CW-1] != '1);
      if (clip[i]) begin
        res_d[i] = sum[i][UW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end else begin
        res_d[i] = sum[i][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pt4_q <= pt_i;
      hi_q  <= hi_d;
      lo_q  <= lo_d;
    end
    if (en_i[1]) begin
      pt5_q  <= pt4_q;
      step_q <= step_d;
    end
    if (en_i[2]) begin
      out_q.x <= res_d[0];
      out_q.y <= res_d[1];
      out_q.z <= res_d[2];
      sat_q   <= |clip;
    end
  end

  assign pt_o  = out_q;
  assign sat_o = sat_q;

endmodule
`default_nettype wire
